// ----- rtl/pce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pce_pkg
// Shared constants, types and helper functions of the punycode hostname encoder.
// ============================================================================
package pce_pkg;

    // Field widths.
    localparam int CP_W   = 21;
    localparam int CH_W   = 7;
    localparam int DATA_W = 32;

    // Label storage default depth.
    localparam int MAX_LABEL_CHARS_DEF = 64;

    // Encoded label buffer: at most 63 characters per label.
    localparam int ENC_MAX   = 63;
    localparam int ENC_DEPTH = 64;
    localparam int ENC_AW    = 6;

    // Punycode parameters.
    localparam int PC_BASE  = 36;
    localparam int PC_TMIN  = 1;
    localparam int PC_TMAX  = 26;
    localparam int PC_SKEW  = 38;
    localparam int PC_DAMP  = 700;
    localparam int PC_BIAS0 = 72;
    localparam int PC_N0    = 128;
    localparam int PC_BLIM  = ((PC_BASE - PC_TMIN) * PC_TMAX) / 2;

    // Characters.
    localparam logic [CH_W-1:0] CH_DOT  = 7'h2E;
    localparam logic [CH_W-1:0] CH_DASH = 7'h2D;
    localparam logic [CH_W-1:0] CH_X    = 7'h78;
    localparam logic [CH_W-1:0] CH_N    = 7'h6E;
    localparam logic [CH_W-1:0] CH_A    = 7'h61;
    localparam logic [CH_W-1:0] CH_ZERO = 7'h30;
    localparam logic [CP_W-1:0] CP_DOT  = 21'h2E;

    // Divider request and response.
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] rem;
    } div_rsp_t;

    // Map a digit value 0..35 to 'a'..'z', '0'..'9'.
    function automatic logic [CH_W-1:0] digit_char(input logic [5:0] d);
        logic [CH_W-1:0] c;
        if (d < 6'd26)
        begin
            c = CH_A + CH_W'(d);
        end
        else
        begin
            c = CH_ZERO + CH_W'(d - 6'd26);
        end
        return c;
    endfunction

    // Characters of the "xn--" prefix.
    function automatic logic [CH_W-1:0] hdr_char(input logic [1:0] i);
        logic [CH_W-1:0] c;
        unique case (i)
            2'd0: c = CH_X;
            2'd1: c = CH_N;
            default: c = CH_DASH;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pce_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pce_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ============================================================================
module pce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds when no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pce_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pce_div
// Restoring divider, one quotient bit per cycle, shared by the encoder.
// ============================================================================
module pce_div
    import pce_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W:0]   trial;

    // One shift-subtract step per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DATA_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DATA_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

`ifndef SYNTHESIS
    // A new division is never requested while one is in progress.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("divider restarted while busy");

    // The result is announced exactly once, right after the last step.
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished division");

    // A division takes its full number of steps.
    a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> cnt_reg == CNT_W'(DATA_W))
        else $error("divider started with a wrong step count");
`endif

endmodule
`default_nettype wire

// ----- rtl/punycode_hostname_encoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// punycode_hostname_encoder
// Encodes a hostname given as Unicode code points into punycode labels.
// ============================================================================
// Usage:
// The input channel (in_valid, in_stall, code_point, last) takes one code
// point per beat. Code points are stored in the label memory; a '.' beat or a
// beat with last set ends the label, and the block then stalls its input
// until the whole encoding of the label has been handed to the output channel.
// The output channel (out_valid, out_stall, out_char, ...) carries one ASCII
// character per beat; last_of_run marks the final beat caused by an input
// beat, end_of_host marks a run that ends the hostname, and overflow flags a
// truncated label. Beats that do not end a label are taken without a stall.
// A label end costs a pass over the stored code points for each scan of the
// label memory (two scans for an ASCII label; a wide label takes two scans,
// then two more per distinct non-ASCII value), plus a division in the shared
// bit-serial divider for each emitted delta digit above the threshold and two
// per bias adaptation, plus the constant divisions of the bias adaptation,
// done as reciprocal products, plus the drain of each output character.
// A stalled output holds its beat and pauses the drain of the encoded buffer.
// Reset clears the label count, the flags and the output register; the
// memories need no clearing.
// ============================================================================
module punycode_hostname_encoder
    import pce_pkg::*;
#(
    parameter int MAX_LABEL_CHARS = MAX_LABEL_CHARS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [CP_W-1:0] code_point,
    input  wire logic            last,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic      [CH_W-1:0] out_char,
    output logic                 last_of_run,
    output logic                 end_of_host,
    output logic                 overflow
);

    localparam int CW = $clog2(MAX_LABEL_CHARS + 1);
    localparam int AW = (MAX_LABEL_CHARS > 1) ? $clog2(MAX_LABEL_CHARS) : 1;
    localparam int NW = CP_W + 1;
    localparam int KW = 16;

    // Reciprocals for the constant divisions of the bias adaptation. Both are
    // exact for dividends below 2^30, which delta never reaches with 21-bit
    // code points and at most 256 code points per label.
    localparam logic [30:0] RCP35  = 31'd1963413622;
    localparam logic [28:0] RCP175 = 29'd392682725;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_WIDE_RD = 5'd1;
    localparam logic [4:0] S_WIDE_EV = 5'd2;
    localparam logic [4:0] S_COPY_RD = 5'd3;
    localparam logic [4:0] S_COPY_EV = 5'd4;
    localparam logic [4:0] S_HDR     = 5'd5;
    localparam logic [4:0] S_BAS_RD  = 5'd6;
    localparam logic [4:0] S_BAS_EV  = 5'd7;
    localparam logic [4:0] S_ROUND   = 5'd8;
    localparam logic [4:0] S_MIN_RD  = 5'd9;
    localparam logic [4:0] S_MIN_EV  = 5'd10;
    localparam logic [4:0] S_MULT    = 5'd11;
    localparam logic [4:0] S_ADD     = 5'd12;
    localparam logic [4:0] S_SCAN_RD = 5'd13;
    localparam logic [4:0] S_SCAN_EV = 5'd14;
    localparam logic [4:0] S_DIG     = 5'd15;
    localparam logic [4:0] S_DIG_W   = 5'd16;
    localparam logic [4:0] S_BA0     = 5'd17;
    localparam logic [4:0] S_BA1     = 5'd19;
    localparam logic [4:0] S_BA1_W   = 5'd20;
    localparam logic [4:0] S_BA2     = 5'd21;
    localparam logic [4:0] S_BA3_W   = 5'd23;
    localparam logic [4:0] S_DR_RD   = 5'd24;
    localparam logic [4:0] S_DR_LD   = 5'd25;
    localparam logic [4:0] S_DR_DOT  = 5'd26;

    logic [4:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              tl_reg, tl_next;
    logic              dot_reg, dot_next;
    logic              last_reg, last_next;
    logic              wide_reg, wide_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     basic_reg, basic_next;
    logic [CW-1:0]     h_reg, h_next;
    logic [1:0]        hdr_reg, hdr_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     m_reg, m_next;
    logic [DATA_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0] delta_reg, delta_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [KW-1:0]     bias_reg, bias_next;
    logic [5:0]        t_reg, t_next;
    logic [ENC_AW-1:0] enc_len_reg, enc_len_next;
    logic              cut_reg, cut_next;
    logic [ENC_AW-1:0] ridx_reg, ridx_next;

    logic              ov_reg, ov_next;
    logic [CH_W-1:0]   oc_reg, oc_next;
    logic              olr_reg, olr_next;
    logic              oeh_reg, oeh_next;
    logic              oof_reg, oof_next;

    logic              lab_we, lab_re;
    logic [AW-1:0]     lab_waddr, lab_raddr;
    logic [CP_W-1:0]   lab_rdata;
    logic              enc_we, enc_re;
    logic [ENC_AW-1:0] enc_raddr;
    logic [CH_W-1:0]   enc_rdata;

    logic              put_en;
    logic [CH_W-1:0]   put_ch;
    logic              out_free;
    logic              in_dot;
    logic [NW-1:0]     cp_ext;
    logic [CW:0]       hp1;
    logic [NW+CW:0]    prod_full;
    logic [5:0]        t_c;
    logic [60:0]       q35_full;
    logic [56:0]       q700_full;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // Label memory and encoded character buffer.
    pce_ram #(
        .WIDTH (CP_W),
        .DEPTH (MAX_LABEL_CHARS),
        .AW    (AW)
    ) u_lab_ram (
        .clk   (clk),
        .we    (lab_we),
        .waddr (lab_waddr),
        .wdata (code_point),
        .re    (lab_re),
        .raddr (lab_raddr),
        .rdata (lab_rdata)
    );

    pce_ram #(
        .WIDTH (CH_W),
        .DEPTH (ENC_DEPTH),
        .AW    (ENC_AW)
    ) u_enc_ram (
        .clk   (clk),
        .we    (enc_we),
        .waddr (enc_len_reg),
        .wdata (put_ch),
        .re    (enc_re),
        .raddr (enc_raddr),
        .rdata (enc_rdata)
    );

    pce_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Small datapath helpers.
    assign in_dot    = (code_point == CP_DOT);
    assign cp_ext    = {1'b0, lab_rdata};
    assign hp1       = {1'b0, h_reg} + 1'b1;
    assign prod_full = (m_reg - n_reg) * hp1;
    assign out_free  = !ov_reg || !out_stall;

    // Division by 35 and by 700 (a shift by two, then 175) as reciprocal products.
    assign q35_full  = 61'(d_reg[29:0]) * 61'(RCP35);
    assign q700_full = 57'(delta_reg[29:2]) * 57'(RCP175);

    // Digit threshold from k and bias.
    always_comb
    begin
        if (k_reg <= bias_reg)
        begin
            t_c = 6'(PC_TMIN);
        end
        else if (k_reg >= bias_reg + KW'(PC_TMAX))
        begin
            t_c = 6'(PC_TMAX);
        end
        else
        begin
            t_c = 6'(k_reg - bias_reg);
        end
    end

    // Main sequencer.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        tl_next      = tl_reg;
        dot_next     = dot_reg;
        last_next    = last_reg;
        wide_next    = wide_reg;
        idx_next     = idx_reg;
        basic_next   = basic_reg;
        h_next       = h_reg;
        hdr_next     = hdr_reg;
        n_next       = n_reg;
        m_next       = m_reg;
        prod_next    = prod_reg;
        delta_next   = delta_reg;
        q_next       = q_reg;
        d_next       = d_reg;
        k_next       = k_reg;
        bias_next    = bias_reg;
        t_next       = t_reg;
        enc_len_next = enc_len_reg;
        cut_next     = cut_reg;
        ridx_next    = ridx_reg;
        ov_next      = ov_reg;
        oc_next      = oc_reg;
        olr_next     = olr_reg;
        oeh_next     = oeh_reg;
        oof_next     = oof_reg;
        lab_we       = 1'b0;
        lab_waddr    = cnt_reg[AW-1:0];
        lab_re       = 1'b0;
        lab_raddr    = idx_reg[AW-1:0];
        enc_re       = 1'b0;
        enc_raddr    = ridx_reg;
        put_en       = 1'b0;
        put_ch       = lab_rdata[CH_W-1:0];
        div_req      = '0;

        // Output register drains when the receiver takes the beat.
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!in_dot)
                    begin
                        if (cnt_reg < CW'(MAX_LABEL_CHARS))
                        begin
                            lab_we   = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            tl_next = 1'b1;
                        end
                    end
                    if (in_dot || last)
                    begin
                        dot_next     = in_dot;
                        last_next    = last;
                        wide_next    = 1'b0;
                        idx_next     = '0;
                        basic_next   = '0;
                        enc_len_next = '0;
                        cut_next     = 1'b0;
                        state_next   = S_WIDE_RD;
                    end
                end
            end
            S_WIDE_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    idx_next   = '0;
                    hdr_next   = '0;
                    state_next = wide_reg ? S_HDR : S_COPY_RD;
                end
                else
                begin
                    lab_re     = 1'b1;
                    state_next = S_WIDE_EV;
                end
            end
            S_WIDE_EV:
            begin
                if (cp_ext >= NW'(PC_N0))
                begin
                    wide_next = 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_WIDE_RD;
            end
            S_COPY_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    ridx_next  = '0;
                    state_next = S_DR_RD;
                end
                else
                begin
                    lab_re     = 1'b1;
                    state_next = S_COPY_EV;
                end
            end
            S_COPY_EV:
            begin
                put_en     = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = S_COPY_RD;
            end
            S_HDR:
            begin
                put_en   = 1'b1;
                put_ch   = hdr_char(hdr_reg);
                hdr_next = hdr_reg + 1'b1;
                if (hdr_reg == 2'd3)
                begin
                    state_next = S_BAS_RD;
                end
            end
            S_BAS_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    if (basic_reg != '0)
                    begin
                        put_en = 1'b1;
                        put_ch = CH_DASH;
                    end
                    h_next     = basic_reg;
                    n_next     = NW'(PC_N0);
                    delta_next = '0;
                    bias_next  = KW'(PC_BIAS0);
                    state_next = S_ROUND;
                end
                else
                begin
                    lab_re     = 1'b1;
                    state_next = S_BAS_EV;
                end
            end
            S_BAS_EV:
            begin
                if (cp_ext < NW'(PC_N0))
                begin
                    put_en     = 1'b1;
                    basic_next = basic_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_BAS_RD;
            end
            S_ROUND:
            begin
                if (h_reg == cnt_reg)
                begin
                    ridx_next  = '0;
                    state_next = S_DR_RD;
                end
                else
                begin
                    idx_next   = '0;
                    m_next     = '1;
                    state_next = S_MIN_RD;
                end
            end
            S_MIN_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    state_next = S_MULT;
                end
                else
                begin
                    lab_re     = 1'b1;
                    state_next = S_MIN_EV;
                end
            end
            S_MIN_EV:
            begin
                if (cp_ext >= n_reg && cp_ext < m_reg)
                begin
                    m_next = cp_ext;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_MIN_RD;
            end
            S_MULT:
            begin
                prod_next  = DATA_W'(prod_full);
                n_next     = m_reg;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                delta_next = delta_reg + prod_reg;
                idx_next   = '0;
                state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    delta_next = delta_reg + 1'b1;
                    n_next     = n_reg + 1'b1;
                    state_next = S_ROUND;
                end
                else
                begin
                    lab_re     = 1'b1;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                if (cp_ext < n_reg)
                begin
                    delta_next = delta_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
                else if (cp_ext == n_reg)
                begin
                    q_next     = delta_reg;
                    k_next     = KW'(PC_BASE);
                    state_next = S_DIG;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_DIG:
            begin
                if (q_reg < DATA_W'(t_c))
                begin
                    put_en     = 1'b1;
                    put_ch     = digit_char(q_reg[5:0]);
                    state_next = S_BA0;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = q_reg - DATA_W'(t_c);
                    div_req.divisor  = DATA_W'(PC_BASE) - DATA_W'(t_c);
                    t_next           = t_c;
                    state_next       = S_DIG_W;
                end
            end
            S_DIG_W:
            begin
                if (div_rsp.done)
                begin
                    put_en     = 1'b1;
                    put_ch     = digit_char(t_reg + div_rsp.rem[5:0]);
                    q_next     = div_rsp.quo;
                    k_next     = k_reg + KW'(PC_BASE);
                    state_next = S_DIG;
                end
            end
            S_BA0:
            begin
                if (h_reg == basic_reg)
                begin
                    d_next = DATA_W'(q700_full[56:36]);
                end
                else
                begin
                    d_next = delta_reg >> 1;
                end
                state_next = S_BA1;
            end
            S_BA1:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = d_reg;
                div_req.divisor  = DATA_W'(hp1);
                state_next       = S_BA1_W;
            end
            S_BA1_W:
            begin
                if (div_rsp.done)
                begin
                    d_next     = d_reg + div_rsp.quo;
                    k_next     = '0;
                    state_next = S_BA2;
                end
            end
            S_BA2:
            begin
                if (d_reg > DATA_W'(PC_BLIM))
                begin
                    d_next = DATA_W'(q35_full[60:36]);
                    k_next = k_reg + KW'(PC_BASE);
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DATA_W'(d_reg * DATA_W'(PC_BASE - PC_TMIN + 1));
                    div_req.divisor  = d_reg + DATA_W'(PC_SKEW);
                    state_next       = S_BA3_W;
                end
            end
            S_BA3_W:
            begin
                if (div_rsp.done)
                begin
                    bias_next  = k_reg + div_rsp.quo[KW-1:0];
                    delta_next = '0;
                    h_next     = h_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_DR_RD:
            begin
                if (ridx_reg != enc_len_reg)
                begin
                    enc_re     = 1'b1;
                    state_next = S_DR_LD;
                end
                else if (dot_reg)
                begin
                    state_next = S_DR_DOT;
                end
                else
                begin
                    cnt_next   = '0;
                    tl_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_DR_LD:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oc_next    = enc_rdata;
                    olr_next   = (ENC_AW'(ridx_reg + 1'b1) == enc_len_reg) && !dot_reg;
                    oeh_next   = last_reg;
                    oof_next   = tl_reg || cut_reg;
                    ridx_next  = ridx_reg + 1'b1;
                    state_next = S_DR_RD;
                end
            end
            S_DR_DOT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oc_next    = CH_DOT;
                    olr_next   = 1'b1;
                    oeh_next   = last_reg;
                    oof_next   = tl_reg || cut_reg;
                    cnt_next   = '0;
                    tl_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Append to the encoded buffer, or note the truncation.
        enc_we = 1'b0;
        if (put_en)
        begin
            if (enc_len_reg != ENC_AW'(ENC_MAX))
            begin
                enc_we       = 1'b1;
                enc_len_next = enc_len_reg + 1'b1;
            end
            else
            begin
                cut_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            tl_reg      <= 1'b0;
            dot_reg     <= 1'b0;
            last_reg    <= 1'b0;
            wide_reg    <= 1'b0;
            idx_reg     <= '0;
            basic_reg   <= '0;
            h_reg       <= '0;
            hdr_reg     <= '0;
            n_reg       <= '0;
            m_reg       <= '0;
            prod_reg    <= '0;
            delta_reg   <= '0;
            q_reg       <= '0;
            d_reg       <= '0;
            k_reg       <= '0;
            bias_reg    <= '0;
            t_reg       <= '0;
            enc_len_reg <= '0;
            cut_reg     <= 1'b0;
            ridx_reg    <= '0;
            ov_reg      <= 1'b0;
            oc_reg      <= '0;
            olr_reg     <= 1'b0;
            oeh_reg     <= 1'b0;
            oof_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            tl_reg      <= tl_next;
            dot_reg     <= dot_next;
            last_reg    <= last_next;
            wide_reg    <= wide_next;
            idx_reg     <= idx_next;
            basic_reg   <= basic_next;
            h_reg       <= h_next;
            hdr_reg     <= hdr_next;
            n_reg       <= n_next;
            m_reg       <= m_next;
            prod_reg    <= prod_next;
            delta_reg   <= delta_next;
            q_reg       <= q_next;
            d_reg       <= d_next;
            k_reg       <= k_next;
            bias_reg    <= bias_next;
            t_reg       <= t_next;
            enc_len_reg <= enc_len_next;
            cut_reg     <= cut_next;
            ridx_reg    <= ridx_next;
            ov_reg      <= ov_next;
            oc_reg      <= oc_next;
            olr_reg     <= olr_next;
            oeh_reg     <= oeh_next;
            oof_reg     <= oof_next;
        end
    end

    // Port drive.
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = ov_reg;
    assign out_char    = oc_reg;
    assign last_of_run = olr_reg;
    assign end_of_host = oeh_reg;
    assign overflow    = oof_reg;

`ifndef SYNTHESIS
    // Truncation of the encoding only happens once the buffer is full.
    a_cut_full: assert property (@(posedge clk) disable iff (!rst_n)
        cut_reg |-> enc_len_reg == ENC_AW'(ENC_MAX))
        else $error("encoding cut before the buffer was full");

    // A dropped code point means the label memory is full.
    a_tl_full: assert property (@(posedge clk) disable iff (!rst_n)
        tl_reg |-> cnt_reg == CW'(MAX_LABEL_CHARS))
        else $error("label flagged too long while not full");

    // The label count never passes the memory depth.
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_LABEL_CHARS))
        else $error("label count beyond memory depth");

    // While a label is being encoded, no scan runs past the stored label.
    a_idx_max: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> idx_reg <= cnt_reg)
        else $error("scan index beyond label length");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_punycode_hostname_encoder.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_punycode_hostname_encoder
// Self-checking bench for the punycode hostname encoder. Hostnames are fed
// one code point per beat; a behavioral encoder predicts every output
// character and its flags, and a monitor compares each output beat in order.
// ============================================================================
module tb_punycode_hostname_encoder;
    import pce_pkg::*;

    localparam int LABEL_MAX = 64;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            lst;
    } cp_beat_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            run_end;
        logic            host_end;
        logic            ovf;
    } char_beat_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    logic [CP_W-1:0] code_point = '0;
    logic            last = 1'b0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [CH_W-1:0] out_char;
    logic            last_of_run;
    logic            end_of_host;
    logic            overflow;

    cp_beat_t   pending_cps[$];
    char_beat_t expected_chars[$];

    // Predictor state.
    logic [CP_W-1:0] lbl_cps[LABEL_MAX];
    int              lbl_len = 0;
    bit              lbl_dropped = 0;
    byte             enc_chars[$];
    bit              enc_trunc;

    int  errors = 0;
    int  beats_in = 0;
    int  chars_out = 0;
    int  hosts_done = 0;
    bit  rx_hold = 0;
    bit  idle_free = 0;
    bit  tx_pause = 0;

    always #2 clk = ~clk;

    punycode_hostname_encoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_point (code_point),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .last_of_run(last_of_run),
        .end_of_host(end_of_host),
        .overflow   (overflow)
    );

    // Append one encoded character, cutting the label at 63 characters.
    function automatic void emit_enc(input longint unsigned c);
        if (enc_chars.size() < ENC_MAX)
        begin
            enc_chars.push_back(byte'(c & 64'h7F));
        end
        else
        begin
            enc_trunc = 1;
        end
    endfunction

    function automatic longint unsigned to_digit(input longint unsigned d);
        return (d < 26) ? d + 64'h61 : d - 26 + 64'h30;
    endfunction

    function automatic longint unsigned adapt_bias(input longint unsigned d,
                                                   input longint unsigned pts,
                                                   input bit first);
        longint unsigned k;
        k = 0;
        d = first ? d / PC_DAMP : d / 2;
        d += d / pts;
        while (d > PC_BLIM)
        begin
            d /= (PC_BASE - PC_TMIN);
            k += PC_BASE;
        end
        return k + ((PC_BASE - PC_TMIN + 1) * d) / (d + PC_SKEW);
    endfunction

    // Encode the stored label into enc_chars.
    task automatic encode_stored_label();
        longint unsigned n, delta, bias, m, c, q, k, t;
        int  basic, h;
        bit  wide;
        enc_chars.delete();
        enc_trunc = 0;
        wide = 0;
        basic = 0;
        n = PC_N0;
        delta = 0;
        bias = PC_BIAS0;
        for (int i = 0; i < lbl_len; i++)
            if (lbl_cps[i] >= 128) wide = 1;
        if (!wide)
        begin
            for (int i = 0; i < lbl_len; i++)
                emit_enc(lbl_cps[i]);
            return;
        end
        emit_enc(CH_X);
        emit_enc(CH_N);
        emit_enc(CH_DASH);
        emit_enc(CH_DASH);
        for (int i = 0; i < lbl_len; i++)
        begin
            if (lbl_cps[i] < 128)
            begin
                emit_enc(lbl_cps[i]);
                basic++;
            end
        end
        if (basic > 0) emit_enc(CH_DASH);
        h = basic;
        while (h < lbl_len)
        begin
            m = '1;
            for (int i = 0; i < lbl_len; i++)
                if (lbl_cps[i] >= n && lbl_cps[i] < m) m = lbl_cps[i];
            delta += (m - n) * (h + 1);
            n = m;
            for (int i = 0; i < lbl_len; i++)
            begin
                c = lbl_cps[i];
                if (c < n) delta++;
                if (c == n)
                begin
                    q = delta;
                    k = PC_BASE;
                    forever
                    begin
                        if (k <= bias) t = PC_TMIN;
                        else if (k >= bias + PC_TMAX) t = PC_TMAX;
                        else t = k - bias;
                        if (q < t) break;
                        emit_enc(to_digit(t + (q - t) % (PC_BASE - t)));
                        q = (q - t) / (PC_BASE - t);
                        k += PC_BASE;
                    end
                    emit_enc(to_digit(q));
                    bias = adapt_bias(delta, h + 1, h == basic);
                    delta = 0;
                    h++;
                end
            end
            delta++;
            n++;
        end
    endtask

    // Predict the output characters caused by one accepted code point beat.
    task automatic predict_hostname_chars(input cp_beat_t b);
        char_beat_t r;
        bit dot;
        int total;
        dot = (b.cp == CP_DOT);
        if (!dot)
        begin
            if (lbl_len < LABEL_MAX)
            begin
                lbl_cps[lbl_len] = b.cp;
                lbl_len++;
            end
            else
            begin
                lbl_dropped = 1;
            end
            if (!b.lst) return;
        end
        encode_stored_label();
        total = enc_chars.size() + (dot ? 1 : 0);
        for (int i = 0; i < total; i++)
        begin
            r.ch       = (i < enc_chars.size()) ? CH_W'(enc_chars[i]) : CH_DOT;
            r.run_end  = (i + 1 == total);
            r.host_end = b.lst;
            r.ovf      = enc_trunc | lbl_dropped;
            expected_chars.push_back(r);
        end
        if (b.lst) hosts_done++;
        lbl_len = 0;
        lbl_dropped = 0;
    endtask

    // Driver: offers queued beats, with random idle cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_hostname_chars('{code_point, last});
                beats_in++;
                void'(pending_cps.pop_front());
            end
            if ((!in_valid || !in_stall) && !tx_pause)
            begin
                if (pending_cps.size() > 0 &&
                    (idle_free || $urandom_range(99) >= 16))
                begin
                    in_valid   <= 1'b1;
                    code_point <= pending_cps[0].cp;
                    last       <= pending_cps[0].lst;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            else if (tx_pause && !in_stall)
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks every output beat against the oldest prediction.
    always @(posedge clk)
    begin
        char_beat_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                chars_out++;
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected output char %h", out_char);
                    errors++;
                end
                else
                begin
                    e = expected_chars.pop_front();
                    if (out_char !== e.ch)
                    begin
                        $error("out_char: expected %h, actual %h", e.ch, out_char);
                        errors++;
                    end
                    if (last_of_run !== e.run_end)
                    begin
                        $error("last_of_run: expected %b, actual %b", e.run_end,
                               last_of_run);
                        errors++;
                    end
                    if (end_of_host !== e.host_end)
                    begin
                        $error("end_of_host: expected %b, actual %b", e.host_end,
                               end_of_host);
                        errors++;
                    end
                    if (overflow !== e.ovf)
                    begin
                        $error("overflow: expected %b, actual %b", e.ovf, overflow);
                        errors++;
                    end
                end
            end
            out_stall <= rx_hold || (!idle_free && $urandom_range(99) < 16);
        end
    end

    function automatic logic [CP_W-1:0] rand_cp();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) return CP_W'($urandom_range(8'h61, 8'h7A));
        if (sel < 6) return CP_W'($urandom_range(16'h80, 16'h7FF));
        if (sel < 8) return CP_W'($urandom_range(16'h800, 17'h10FFF));
        if (sel == 8) return CP_W'($urandom_range(127));
        return CP_W'($urandom);
    endfunction

    task automatic push_cp(input logic [CP_W-1:0] cp, input bit lst);
        pending_cps.push_back('{cp, lst});
    endtask

    task automatic wait_drained();
        while (pending_cps.size() > 0 || in_valid || expected_chars.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int len, nlab, sent;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ASCII label, lone dot, extremes, dot with last.
        push_cp(21'h61, 0); push_cp(21'h5A, 0); push_cp(21'h0, 0);
        push_cp(CP_DOT, 0);
        push_cp(CP_DOT, 0);
        push_cp(21'h7F, 0); push_cp(21'h80, 0); push_cp(21'h1FFFFF, 0);
        push_cp(21'h10FFFF, 0); push_cp(21'hD800, 0); push_cp(CP_DOT, 0);
        push_cp(21'hE9, 0); push_cp(21'h4E2D, 1);
        push_cp(21'h62, 0); push_cp(CP_DOT, 1);
        push_cp(21'h7F, 1);
        // Overlong input label and overlong encoding.
        for (int i = 0; i < 66; i++) push_cp(21'h71, 0);
        push_cp(CP_DOT, 0);
        for (int i = 0; i < 30; i++) push_cp(CP_W'(21'h100000 + 977 * i), 0);
        push_cp(21'h63, 1);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering.
        for (int i = 0; i < 6; i++) push_cp(21'h6D, 0);
        push_cp(CP_DOT, 0);
        for (int i = 0; i < 6; i++) push_cp(21'h3B1, i == 5);
        rx_hold = 1;
        repeat (400) @(posedge clk);
        rx_hold = 0;
        wait_drained();

        // Random hostnames; a stretch without idling in the middle.
        sent = 0;
        while (sent < 125)
        begin
            idle_free = (sent >= 50 && sent < 75);
            nlab = $urandom_range(1, 3);
            for (int l = 0; l < nlab; l++)
            begin
                len = ($urandom_range(19) == 0) ? $urandom_range(60, 70)
                                                : $urandom_range(0, 8);
                for (int i = 0; i < len; i++) push_cp(rand_cp(), 0);
                sent += len;
                if (l + 1 < nlab || $urandom_range(1))
                begin
                    push_cp(CP_DOT, 0);
                    sent++;
                end
            end
            push_cp(rand_cp(), 1);
            sent++;
            if ($urandom_range(7) == 0)
            begin
                // Sender pauses until everything has come out.
                wait_drained();
                tx_pause = 1;
                repeat (20) @(posedge clk);
                tx_pause = 0;
            end
        end
        idle_free = 0;
        wait_drained();
        repeat (200) @(posedge clk);

        $display("Covered %0d input beats, %0d output chars, %0d hostnames.",
                 beats_in, chars_out, hosts_done);
        if (errors == 0 && expected_chars.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
